### rtl/zctd_pkg.sv
// ----------------------------------------------------------------------------
// zctd_pkg
// Shared types, codes and lookup functions for the Z-character text decoder.
// ----------------------------------------------------------------------------
package zctd_pkg;

    localparam int ZCHAR_W = 5;

    // Result kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_ABBR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_VERSION     = 1'b0;
    localparam logic CFG_ABBREV_BASE = 1'b1;

    localparam logic [3:0] VERSION_RESET = 4'd3;

    // Alphabet codes; the last is the version 1 form of A2.
    localparam logic [1:0] ALPH_A0    = 2'd0;
    localparam logic [1:0] ALPH_A1    = 2'd1;
    localparam logic [1:0] ALPH_A2    = 2'd2;
    localparam logic [1:0] ALPH_A2_V1 = 2'd3;

    // One queued word, already split into its three Z-characters.
    typedef struct packed {
        logic [ZCHAR_W-1:0] z0;
        logic [ZCHAR_W-1:0] z1;
        logic [ZCHAR_W-1:0] z2;
        logic               text_end;
        logic [15:0]        bytes_used;
    } qentry_t;

    function automatic logic [1:0] rot_up(input logic [1:0] a);
        case (a)
            ALPH_A0: rot_up = ALPH_A1;
            ALPH_A1: rot_up = ALPH_A2;
            default: rot_up = ALPH_A0;
        endcase
    endfunction

    function automatic logic [1:0] rot_down(input logic [1:0] a);
        case (a)
            ALPH_A0: rot_down = ALPH_A2;
            ALPH_A1: rot_down = ALPH_A0;
            default: rot_down = ALPH_A1;
        endcase
    endfunction

    // Punctuation row A2 as used from version 2 onwards.
    function automatic logic [7:0] a2_char(input logic [4:0] idx);
        case (idx)
            5'd0:  a2_char = 8'h20;
            5'd1:  a2_char = 8'h0A;
            5'd2:  a2_char = 8'h30;
            5'd3:  a2_char = 8'h31;
            5'd4:  a2_char = 8'h32;
            5'd5:  a2_char = 8'h33;
            5'd6:  a2_char = 8'h34;
            5'd7:  a2_char = 8'h35;
            5'd8:  a2_char = 8'h36;
            5'd9:  a2_char = 8'h37;
            5'd10: a2_char = 8'h38;
            5'd11: a2_char = 8'h39;
            5'd12: a2_char = 8'h2E;
            5'd13: a2_char = 8'h2C;
            5'd14: a2_char = 8'h21;
            5'd15: a2_char = 8'h3F;
            5'd16: a2_char = 8'h5F;
            5'd17: a2_char = 8'h23;
            5'd18: a2_char = 8'h27;
            5'd19: a2_char = 8'h22;
            5'd20: a2_char = 8'h2F;
            5'd21: a2_char = 8'h5C;
            5'd22: a2_char = 8'h2D;
            5'd23: a2_char = 8'h3A;
            5'd24: a2_char = 8'h28;
            5'd25: a2_char = 8'h29;
            default: a2_char = 8'h00;
        endcase
    endfunction

    // Character at position idx (0 to 25) of the given alphabet row.
    function automatic logic [7:0] alpha_char(input logic [1:0] row, input logic [4:0] idx);
        case (row)
            ALPH_A0: alpha_char = 8'h61 + {3'd0, idx};
            ALPH_A1: alpha_char = 8'h41 + {3'd0, idx};
            ALPH_A2: alpha_char = a2_char(idx);
            default: begin
                // Version 1 row has no newline and carries '<' before '-'.
                if (idx == 5'd0)
                    alpha_char = 8'h20;
                else if (idx <= 5'd20)
                    alpha_char = a2_char(idx + 5'd1);
                else if (idx == 5'd21)
                    alpha_char = 8'h3C;
                else
                    alpha_char = a2_char(idx);
            end
        endcase
    endfunction

endpackage

### rtl/zctd_front.sv
// ----------------------------------------------------------------------------
// zctd_front
// Accepts text words, splits them into Z-characters and keeps the byte count.
// ----------------------------------------------------------------------------
module zctd_front import zctd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // text_word
    input  logic        q_full,
    output logic        q_push,
    output qentry_t     q_data
);

    logic [15:0] byte_cnt_reg;
    logic [15:0] byte_cnt_next;
    logic [15:0] bytes_now;

    assign s_tready  = ~q_full;
    assign q_push    = s_tvalid & ~q_full;
    assign bytes_now = byte_cnt_reg + 16'd2;

    always_comb begin
        q_data.z0         = s_tdata[14:10];
        q_data.z1         = s_tdata[9:5];
        q_data.z2         = s_tdata[4:0];
        q_data.text_end   = s_tdata[15];
        q_data.bytes_used = bytes_now;
    end

    // The count restarts after the word that closes the text.
    always_comb begin
        byte_cnt_next = byte_cnt_reg;
        if (q_push)
            byte_cnt_next = s_tdata[15] ? 16'd0 : bytes_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            byte_cnt_reg <= 16'd0;
        else
            byte_cnt_reg <= byte_cnt_next;
    end

endmodule

### rtl/zctd_queue.sv
// ----------------------------------------------------------------------------
// zctd_queue
// Two-entry queue between the front end and the decode sequencer.
// ----------------------------------------------------------------------------
module zctd_queue import zctd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  qentry_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    head_valid,
    output qentry_t head_data
);

    qentry_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/zctd_back.sv
// ----------------------------------------------------------------------------
// zctd_back
// Decode sequencer: one Z-character a cycle against the alphabet state while
// the output is not stalled, giving a registered result beat.
// ----------------------------------------------------------------------------
module zctd_back import zctd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        head_valid,
    input  qentry_t     head_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic [3:0]  version_reg;
    logic [15:0] base_reg;

    logic [1:0]  pos_reg;
    logic [1:0]  alph_reg,  alph_next;
    logic        lock_reg,  lock_next;
    logic [1:0]  bank_reg,  bank_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  char_reg;
    logic [15:0] addr_reg;
    logic        last_reg;
    logic        end_reg;
    logic [15:0] bytes_reg;

    logic        step;
    logic        is_last;
    logic [4:0]  zc;
    logic [1:0]  row;
    logic [1:0]  kind_d;
    logic [7:0]  char_d;
    logic [15:0] addr_d;

    assign step    = head_valid & (~out_valid_reg | m_tready);
    assign is_last = (pos_reg == 2'd2);
    assign pop     = step & is_last;

    always_comb begin
        case (pos_reg)
            2'd0:    zc = head_data.z0;
            2'd1:    zc = head_data.z1;
            default: zc = head_data.z2;
        endcase
    end

    always_comb begin
        row = (alph_reg == ALPH_A2_V1) ? ALPH_A0 : alph_reg;
        if (row == ALPH_A2 && version_reg == 4'd1)
            row = ALPH_A2_V1;
    end

    always_comb begin
        kind_d    = KIND_NONE;
        char_d    = 8'd0;
        addr_d    = 16'd0;
        alph_next = alph_reg;
        lock_next = lock_reg;
        bank_next = bank_reg;
        if (bank_reg != 2'd0) begin
            // The character after a bank code selects the table entry.
            kind_d    = KIND_ABBR;
            addr_d    = base_reg + {8'd0, bank_reg - 2'd1, 6'd0} + {10'd0, zc, 1'b0};
            bank_next = 2'd0;
        end else if (zc > 5'd5) begin
            kind_d = KIND_CHAR;
            char_d = alpha_char(row, zc - 5'd6);
            if (alph_reg != ALPH_A0 && !lock_reg)
                alph_next = ALPH_A0;
        end else begin
            case (zc)
                5'd0: begin
                    kind_d = KIND_CHAR;
                    char_d = 8'h20;
                end
                5'd1: begin
                    if (version_reg == 4'd1) begin
                        kind_d = KIND_CHAR;
                        char_d = 8'h0A;
                    end else begin
                        bank_next = 2'd1;
                    end
                end
                5'd2, 5'd3: begin
                    if (version_reg >= 4'd3)
                        bank_next = zc[1:0];
                    else
                        alph_next = (zc == 5'd2) ? rot_up(alph_reg) : rot_down(alph_reg);
                end
                default: begin
                    if (version_reg < 4'd3)
                        lock_next = 1'b1;
                    alph_next = (zc == 5'd4) ? rot_up(alph_reg) : rot_down(alph_reg);
                end
            endcase
        end
        // All text state clears once the closing word has been decoded.
        if (is_last && head_data.text_end) begin
            alph_next = ALPH_A0;
            lock_next = 1'b0;
            bank_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= VERSION_RESET;
            base_reg    <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VERSION:     version_reg <= cfg_wdata[3:0];
                CFG_ABBREV_BASE: base_reg    <= cfg_wdata;
                default:         base_reg    <= base_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 2'd0;
            alph_reg      <= ALPH_A0;
            lock_reg      <= 1'b0;
            bank_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                pos_reg  <= is_last ? 2'd0 : pos_reg + 2'd1;
                alph_reg <= alph_next;
                lock_reg <= lock_next;
                bank_reg <= bank_next;
            end
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            kind_reg  <= kind_d;
            char_reg  <= char_d;
            addr_reg  <= addr_d;
            last_reg  <= is_last;
            end_reg   <= is_last & head_data.text_end;
            bytes_reg <= head_data.bytes_used;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {bytes_reg, addr_reg, char_reg};
    assign m_tuser  = {end_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

### rtl/zchar_text_decoder_unit.sv
// ----------------------------------------------------------------------------
// zchar_text_decoder_unit
// Z-machine text decoder: 16-bit text words in, one result beat per
// Z-character out.
// ----------------------------------------------------------------------------
// Each accepted word gives exactly three result beats, the third with tlast
// set. Words are taken one a cycle into a two-entry queue while it has room;
// the decode sequencer behind it handles one Z-character a cycle while the
// result channel is not stalled, so a new word can be queued before the last
// is through. A word's first result passes the queue and then the registered
// result beat. Alphabet, shift lock, pending abbreviation bank and byte
// count carry from word to word and clear after a word with bit 15 set.
// Configuration (index 0: story version, index 1: abbreviation table base)
// is to be written only while the unit is idle; the unit does not enforce it.
module zchar_text_decoder_unit import zctd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] text_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] char_code, [23:8] abbrev_entry_address,
                                   // [39:24] bytes_used
    output logic [2:0]  m_tuser,   // [1:0] result_kind, [2] text_end
    output logic        m_tlast    // last_of_word
);

    logic    q_full;
    logic    q_push;
    qentry_t q_data;
    logic    q_pop;
    logic    head_valid;
    qentry_t head_data;

    zctd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    zctd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    zctd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### rtl/zctd_checker.sv
// ----------------------------------------------------------------------------
// zctd_checker
// Port-level checks for the text decoder, bound to the top level.
// ----------------------------------------------------------------------------
module zctd_checker import zctd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result beat holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The end of the text can only be flagged on the last beat of a word.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("text end flagged before the last beat of a word");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != KIND_CHAR |-> m_tdata[7:0] == 8'd0)
        else $error("character code set on a non-character beat");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != KIND_ABBR |-> m_tdata[23:8] == 16'd0)
        else $error("entry address set on a non-abbreviation beat");

endmodule

bind zchar_text_decoder_unit zctd_checker u_zctd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### dv/zctd_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zctd_result_checker
// Watches both streams of the Z-character text decoder, keeps its own copy
// of the alphabet, shift-lock, abbreviation-bank and byte-count state, and
// compares every result beat with the decode it predicts for the word.
// ----------------------------------------------------------------------------

package zctd_tb_pkg;

    // Z-character values with a special meaning; 6 to 31 index an alphabet row.
    localparam logic [4:0] ZC_SPACE      = 5'd0;
    localparam logic [4:0] ZC_NL_BANK1   = 5'd1;
    localparam logic [4:0] ZC_UP         = 5'd2;
    localparam logic [4:0] ZC_DOWN       = 5'd3;
    localparam logic [4:0] ZC_LOCK_UP    = 5'd4;
    localparam logic [4:0] ZC_LOCK_DOWN  = 5'd5;
    localparam logic [4:0] ZC_FIRST_CHAR = 5'd6;
    localparam logic [4:0] ZC_LAST_CHAR  = 5'd31;

endpackage

module zctd_result_checker import zctd_pkg::*, zctd_tb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int unsigned mismatch_count,
    output int unsigned results_due
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [15:0] abbr_addr;
        logic        last_of_word;
        logic        text_end;
        logic [15:0] bytes_used;
    } zresult_t;

    localparam logic [8*26-1:0] ROW_A0    = "abcdefghijklmnopqrstuvwxyz";
    localparam logic [8*26-1:0] ROW_A1    = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam logic [8*26-1:0] ROW_A2    = " \n0123456789.,!?_#'\"/\\-:()";
    localparam logic [8*26-1:0] ROW_A2_V1 = " 0123456789.,!?_#'\"/\\<-:()";

    logic [3:0]  story_version;
    logic [15:0] abbr_base;
    logic [1:0]  alphabet;
    logic        locked;
    logic [1:0]  abbr_bank;
    logic [15:0] byte_total;
    zresult_t    due_results[$];

    function automatic logic [1:0] alph_step(input logic [1:0] a, input logic up);
        case (a)
            ALPH_A0: alph_step = up ? ALPH_A1 : ALPH_A2;
            ALPH_A1: alph_step = up ? ALPH_A2 : ALPH_A0;
            default: alph_step = up ? ALPH_A0 : ALPH_A1;
        endcase
    endfunction

    task automatic clear_text();
        alphabet   = ALPH_A0;
        locked     = 1'b0;
        abbr_bank  = 2'd0;
        byte_total = 16'd0;
    endtask

    // Decodes one Z-character against the running state and advances it.
    task automatic decode_zchar(input logic [4:0] z, output zresult_t r);
        logic [8*26-1:0] row;
        logic [4:0]      idx;
        r = '0;
        if (abbr_bank != 2'd0) begin
            r.kind      = KIND_ABBR;
            r.abbr_addr = abbr_base + ({14'd0, abbr_bank - 2'd1} << 6)
                        + {10'd0, z, 1'b0};
            abbr_bank   = 2'd0;
        end else if (z >= ZC_FIRST_CHAR) begin
            idx = z - ZC_FIRST_CHAR;
            case (alphabet)
                ALPH_A1: row = ROW_A1;
                ALPH_A2: row = (story_version == 4'd1) ? ROW_A2_V1 : ROW_A2;
                default: row = ROW_A0;
            endcase
            r.kind      = KIND_CHAR;
            r.char_code = row[8*(25-idx) +: 8];
            if (!locked)
                alphabet = ALPH_A0;
        end else begin
            case (z)
                ZC_SPACE: begin
                    r.kind      = KIND_CHAR;
                    r.char_code = 8'h20;
                end
                ZC_NL_BANK1: begin
                    if (story_version == 4'd1) begin
                        r.kind      = KIND_CHAR;
                        r.char_code = 8'h0A;
                    end else begin
                        abbr_bank = 2'd1;
                    end
                end
                ZC_UP, ZC_DOWN: begin
                    if (story_version >= 4'd3)
                        abbr_bank = z[1:0];
                    else
                        alphabet = alph_step(alphabet, z == ZC_UP);
                end
                default: begin
                    // Early versions turn the shift into a lock that lasts
                    // until the end of the text.
                    if (story_version < 4'd3)
                        locked = 1'b1;
                    alphabet = alph_step(alphabet, z == ZC_LOCK_UP);
                end
            endcase
        end
    endtask

    task automatic predict_word(input logic [15:0] w);
        zresult_t r;
        logic [4:0] z;
        byte_total = byte_total + 16'd2;
        for (int k = 0; k < 3; k++) begin
            z = (k == 0) ? w[14:10] : (k == 1) ? w[9:5] : w[4:0];
            decode_zchar(z, r);
            r.last_of_word = (k == 2);
            r.text_end     = (k == 2) && w[15];
            r.bytes_used   = byte_total;
            due_results.push_back(r);
        end
        if (w[15])
            clear_text();
    endtask

    task automatic check_beat(input zresult_t got);
        zresult_t want;
        logic     bad;
        if (due_results.size() == 0) begin
            $error("result beat arrived with no decode waiting for it");
            mismatch_count++;
            return;
        end
        want = due_results.pop_front();
        bad  = 1'b0;
        if (got.kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
            bad = 1'b1;
        end
        if (got.char_code !== want.char_code) begin
            $error("char_code: expected %0h, got %0h", want.char_code, got.char_code);
            bad = 1'b1;
        end
        if (got.abbr_addr !== want.abbr_addr) begin
            $error("abbrev_entry_address: expected %0h, got %0h",
                   want.abbr_addr, got.abbr_addr);
            bad = 1'b1;
        end
        if (got.last_of_word !== want.last_of_word) begin
            $error("last_of_word: expected %0d, got %0d",
                   want.last_of_word, got.last_of_word);
            bad = 1'b1;
        end
        if (got.text_end !== want.text_end) begin
            $error("text_end: expected %0d, got %0d", want.text_end, got.text_end);
            bad = 1'b1;
        end
        if (got.bytes_used !== want.bytes_used) begin
            $error("bytes_used: expected %0h, got %0h", want.bytes_used, got.bytes_used);
            bad = 1'b1;
        end
        if (bad)
            mismatch_count++;
    endtask

    always @(posedge aclk) begin
        zresult_t got;
        if (!aresetn) begin
            story_version  = VERSION_RESET;
            abbr_base      = 16'd0;
            mismatch_count = 0;
            clear_text();
            due_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_VERSION:     story_version = cfg_wdata[3:0];
                    CFG_ABBREV_BASE: abbr_base     = cfg_wdata;
                    default:         abbr_base     = abbr_base;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.kind         = m_tuser[1:0];
                got.text_end     = m_tuser[2];
                got.char_code    = m_tdata[7:0];
                got.abbr_addr    = m_tdata[23:8];
                got.bytes_used   = m_tdata[39:24];
                got.last_of_word = m_tlast;
                check_beat(got);
            end
            if (s_tvalid && s_tready)
                predict_word(s_tdata);
        end
        results_due <= due_results.size();
    end

endmodule

### dv/zchar_text_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zchar_text_decoder_unit_tb
// Drives text words into the decoder, first a directed set covering every
// Z-character action and version rule, then random texts under a range of
// versions and table bases, with random gaps on both streams.
// ----------------------------------------------------------------------------

module zchar_text_decoder_unit_tb import zctd_pkg::*; ();

    import zctd_tb_pkg::*;

    localparam int          CLK_PERIOD   = 4;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_WORDS  = 25;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int unsigned mismatch_count;
    int unsigned results_due;
    int unsigned cycle_count = 0;
    int          words_sent = 0;
    int          phase_start;
    int          ready_hold;
    logic        calm = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    zchar_text_decoder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    zctd_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] zword(input logic last_word, input logic [4:0] a,
                                          input logic [4:0] b, input logic [4:0] c);
        return {last_word, a, b, c};
    endfunction

    // Biased towards letters so that texts read on, but shifts and banks stay common.
    function automatic logic [4:0] rand_zchar();
        if ($urandom_range(0, 99) < 62)
            return 5'($urandom_range(ZC_FIRST_CHAR, ZC_LAST_CHAR));
        return 5'($urandom_range(ZC_SPACE, ZC_LOCK_DOWN));
    endfunction

    function automatic logic [3:0] version_for_phase(input int p);
        case (p)
            0: return 4'd3;
            1: return 4'd1;
            2: return 4'd2;
            3: return 4'd8;
            4: return 4'd0;
            5: return 4'd5;
            6: return 4'd9;
            7: return 4'd15;
            8: return 4'd4;
            default: return 4'd1;
        endcase
    endfunction

    // Result sink: ready drops for random stretches between beats.
    initial begin
        m_tready   = 1'b0;
        ready_hold = 0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    ready_hold = pick_gap();
            end
        end
    end

    // Valid stays high across back-to-back words; a gap lowers it first.
    task automatic send_word(input logic [15:0] w);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_mode(input logic [3:0] version, input logic [15:0] base);
        settle();
        write_reg(CFG_VERSION, {12'd0, version});
        write_reg(CFG_ABBREV_BASE, base);
    endtask

    // A run of words, the last with the end mark unless a raw word lands in its slot.
    task automatic send_text();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(16'($urandom));
            else
                send_word(zword(i == len - 1, rand_zchar(), rand_zchar(), rand_zchar()));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_VERSION;
        cfg_wdata = 16'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 16'd0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: version 3, table at address zero.
        send_word(zword(1'b0, ZC_FIRST_CHAR, ZC_FIRST_CHAR + 5'd1, ZC_LAST_CHAR));
        send_word(zword(1'b0, ZC_LOCK_UP, ZC_FIRST_CHAR, ZC_LOCK_DOWN));
        send_word(zword(1'b0, ZC_LAST_CHAR, ZC_SPACE, ZC_FIRST_CHAR + 5'd1));
        send_word(zword(1'b0, ZC_NL_BANK1, ZC_SPACE, ZC_UP));
        send_word(zword(1'b0, ZC_LAST_CHAR, ZC_DOWN, ZC_LAST_CHAR));
        // A bank opened in the last slot is resolved by the next word.
        send_word(zword(1'b0, ZC_SPACE, ZC_SPACE, ZC_DOWN));
        send_word(zword(1'b0, ZC_FIRST_CHAR + 5'd1, ZC_LOCK_UP, ZC_LOCK_UP));
        // A bank still open at the end mark is dropped.
        send_word(zword(1'b1, ZC_FIRST_CHAR + 5'd1, ZC_LOCK_DOWN, ZC_DOWN));
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(zword(1'b1, ZC_LOCK_UP, ZC_FIRST_CHAR + 5'd1, ZC_NL_BANK1));

        // Version 1: newline, shift lock and its own punctuation row.
        set_mode(4'd1, 16'hFFC0);
        send_word(zword(1'b0, ZC_NL_BANK1, ZC_LOCK_UP, ZC_FIRST_CHAR));
        send_word(zword(1'b0, ZC_FIRST_CHAR + 5'd1, ZC_LOCK_UP, ZC_FIRST_CHAR + 5'd1));
        send_word(zword(1'b0, ZC_FIRST_CHAR + 5'd21, ZC_FIRST_CHAR + 5'd22, ZC_LAST_CHAR));
        send_word(zword(1'b0, ZC_UP, ZC_DOWN, ZC_DOWN));
        send_word(zword(1'b1, ZC_LOCK_DOWN, ZC_UP, ZC_LAST_CHAR));
        send_word(zword(1'b0, ZC_UP, ZC_FIRST_CHAR, ZC_FIRST_CHAR));
        send_word(zword(1'b1, ZC_DOWN, ZC_FIRST_CHAR, ZC_SPACE));

        // Version 2: bank 1 only, with the entry address wrapping.
        set_mode(4'd2, 16'hFFE0);
        send_word(zword(1'b0, ZC_NL_BANK1, ZC_LAST_CHAR, ZC_NL_BANK1));
        send_word(zword(1'b0, ZC_LAST_CHAR, ZC_UP, ZC_FIRST_CHAR + 5'd2));
        send_word(zword(1'b0, ZC_DOWN, ZC_FIRST_CHAR, ZC_LOCK_UP));
        send_word(zword(1'b1, ZC_LOCK_DOWN, ZC_FIRST_CHAR, ZC_FIRST_CHAR));

        // Versions outside the documented range.
        set_mode(4'd0, 16'h1234);
        send_word(zword(1'b0, ZC_NL_BANK1, ZC_FIRST_CHAR + 5'd1, ZC_UP));
        send_word(zword(1'b1, ZC_UP, ZC_FIRST_CHAR + 5'd24, ZC_SPACE));
        set_mode(4'd15, 16'hFFFF);
        send_word(zword(1'b0, ZC_DOWN, ZC_LAST_CHAR, ZC_UP));
        send_word(zword(1'b1, ZC_LAST_CHAR, ZC_NL_BANK1, ZC_SPACE));

        for (int p = 0; p < 10; p++) begin
            case (p % 3)
                0:       set_mode(version_for_phase(p), 16'h0000);
                1:       set_mode(version_for_phase(p), 16'hFFFF);
                default: set_mode(version_for_phase(p), 16'($urandom));
            endcase
            calm = (p == 2 || p == 6);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                send_text();
        end

        settle();
        if (mismatch_count == 0 && results_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
